// ===== hw/rtl/sfir_pkg.sv =====
// Shared constants, types and command codes for the stereo FIR filter core.
package sfir_pkg;

  localparam int MAX_TAPS   = 256;
  localparam int ADDR_W     = $clog2(MAX_TAPS);
  localparam int TAPS_W     = $clog2(MAX_TAPS + 1);
  localparam int SAMPLE_W   = 24;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int ACC_W      = PROD_W + ADDR_W;
  localparam int NTAPS_W    = 9;
  localparam int CIDX_W     = 8;
  localparam int CMD_W      = 3;
  localparam int MASK_W     = 2;
  localparam int IN_DATA_W  = 3 * SAMPLE_W + CIDX_W;
  localparam int OUT_DATA_W = 2 * SAMPLE_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MIN_TAPS   = 3;
  localparam int ROUND_SH   = 22;

  localparam logic [CFG_ADDR_W-1:0] REG_NUM_TAPS = '0;
  localparam logic [NTAPS_W-1:0]    NUM_TAPS_RST = NTAPS_W'(255);

  typedef enum logic [CMD_W-1:0] {
    CMD_LEFT  = 3'd0,
    CMD_RIGHT = 3'd1,
    CMD_BOTH  = 3'd2,
    CMD_COEFF = 3'd3,
    CMD_FLUSH = 3'd4
  } cmd_t;

  localparam logic [MASK_W-1:0] MASK_LEFT  = 2'b01;
  localparam logic [MASK_W-1:0] MASK_RIGHT = 2'b10;
  localparam logic [MASK_W-1:0] MASK_BOTH  = 2'b11;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctl_t;

  typedef struct packed {
    logic                       busy;
    logic signed [SAMPLE_W-1:0] y;
  } mac_sts_t;

endpackage

// ===== hw/rtl/sfir_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sfir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/sfir_mac.sv =====
// Multiply-accumulate pipeline with Q1.23 round and saturate.
module sfir_mac
  import sfir_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] coeff,
  input  logic signed [SAMPLE_W-1:0] sample,
  output mac_sts_t                   sts
);

  localparam int Q_W = ACC_W - ROUND_SH;

  logic                     rd_v_r;
  logic                     prod_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [Q_W-1:0]    q;
  logic signed [SAMPLE_W-1:0] y;

  // read data arrives in the cycle after issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= ctl.issue;
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coeff * sample;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then clamp
  always_comb begin
    rnd = acc_r + (ACC_W'(1) <<< (ROUND_SH - 1));
    q   = Q_W'(rnd >>> ROUND_SH);
    if (q > Q_W'(2 ** (SAMPLE_W - 1) - 1)) begin
      y = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (q < -Q_W'(2 ** (SAMPLE_W - 1))) begin
      y = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y = SAMPLE_W'(q);
    end
  end

  assign sts.busy = rd_v_r | prod_v_r;
  assign sts.y    = y;

endmodule

// ===== hw/rtl/stereo_fir_filter_core.sv =====
// Top level of the stereo direct-form FIR filter core.
//
//  channel | direction | tdata / data                     | tuser
//  in_     | request   | sample_left, sample_right,       | command
//          |           | coeff_index, coeff_value         |
//  out_    | result    | out_left, out_right              | channel_mask
//  cfg_    | APB r/w   | num_taps at address 0            | -
//
//  One filtered channel is computed by the single MAC walking the
//  coefficient and delay memories one tap a cycle; both channels run left,
//  then right. Coefficient writes and unused commands leave the core ready.
//  After reset a clearing pass zeroes all 256 entries of all three memories;
//  a flush runs the same pass over both delay lines. in_tready is low
//  during both. A finished result waits in the output register while the
//  next request is taken; the core stalls only when a second result is due.
module stereo_fir_filter_core
  import sfir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sample_left, sample_right, coeff_index, coeff_value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_left, out_right
  output logic [OUT_DATA_W-1:0] out_tdata,
  // channel_mask
  output logic [MASK_W-1:0]     out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  state_t                state_r, state_nxt;
  logic [NTAPS_W-1:0]    num_taps_r, num_taps_nxt;
  logic [ADDR_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic                  clr_coeff_r, clr_coeff_nxt;
  logic [ADDR_W-1:0]     wp_left_r, wp_left_nxt;
  logic [ADDR_W-1:0]     wp_right_r, wp_right_nxt;
  logic [ADDR_W-1:0]     tap_r, tap_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic                  chan_r, chan_nxt;
  logic                  both_r, both_nxt;
  logic [SAMPLE_W-1:0]   sl_r, sl_nxt;
  logic [SAMPLE_W-1:0]   sr_r, sr_nxt;
  logic [SAMPLE_W-1:0]   yl_r, yl_nxt;
  logic [SAMPLE_W-1:0]   yr_r, yr_nxt;
  logic [MASK_W-1:0]     mask_r, mask_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [MASK_W-1:0]     out_tuser_r, out_tuser_nxt;

  logic [TAPS_W-1:0]     n_taps;
  logic [ADDR_W-1:0]     last_tap;
  logic [ADDR_W-1:0]     wp_cur;
  logic [ADDR_W-1:0]     pos;
  logic [TAPS_W-1:0]     pos_inc;
  logic                  in_acc;
  logic                  cfg_wr;
  cmd_t                  cmd;
  logic [CIDX_W-1:0]     cidx;

  logic                  c_we, dl_we, dr_we;
  logic [ADDR_W-1:0]     c_waddr, d_waddr;
  logic [SAMPLE_W-1:0]   c_wdata, d_wdata;
  logic [SAMPLE_W-1:0]   c_rdata, dl_rdata, dr_rdata;
  mac_ctl_t              mac_ctl;
  mac_sts_t              mac_sts;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign cmd        = cmd_t'(in_tuser);
  assign cidx       = in_tdata[2*SAMPLE_W +: CIDX_W];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                      (cfg_paddr == REG_NUM_TAPS);
  assign cfg_prdata = (cfg_paddr == REG_NUM_TAPS) ? CFG_DATA_W'(num_taps_r) : '0;

  always_comb begin
    if (num_taps_r < NTAPS_W'(MIN_TAPS)) begin
      n_taps = TAPS_W'(MIN_TAPS);
    end else if (32'(num_taps_r) > MAX_TAPS) begin
      n_taps = TAPS_W'(MAX_TAPS);
    end else begin
      n_taps = TAPS_W'(num_taps_r);
    end
  end

  assign last_tap = ADDR_W'(n_taps - TAPS_W'(1));
  assign wp_cur   = chan_r ? wp_right_r : wp_left_r;
  assign pos      = (TAPS_W'(wp_cur) >= n_taps) ? '0 : wp_cur;
  assign pos_inc  = TAPS_W'(pos) + TAPS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      num_taps_r   <= NUM_TAPS_RST;
      clr_cnt_r    <= '0;
      clr_coeff_r  <= 1'b1;
      wp_left_r    <= '0;
      wp_right_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      num_taps_r   <= num_taps_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_coeff_r  <= clr_coeff_nxt;
      wp_left_r    <= wp_left_nxt;
      wp_right_r   <= wp_right_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tap_r       <= tap_nxt;
    idx_r       <= idx_nxt;
    chan_r      <= chan_nxt;
    both_r      <= both_nxt;
    sl_r        <= sl_nxt;
    sr_r        <= sr_nxt;
    yl_r        <= yl_nxt;
    yr_r        <= yr_nxt;
    mask_r      <= mask_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    num_taps_nxt   = cfg_wr ? cfg_pwdata[NTAPS_W-1:0] : num_taps_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_coeff_nxt  = clr_coeff_r;
    wp_left_nxt    = wp_left_r;
    wp_right_nxt   = wp_right_r;
    tap_nxt        = tap_r;
    idx_nxt        = idx_r;
    chan_nxt       = chan_r;
    both_nxt       = both_r;
    sl_nxt         = sl_r;
    sr_nxt         = sr_r;
    yl_nxt         = yl_r;
    yr_nxt         = yr_r;
    mask_nxt       = mask_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    c_we           = 1'b0;
    c_waddr        = clr_cnt_r;
    c_wdata        = '0;
    dl_we          = 1'b0;
    dr_we          = 1'b0;
    d_waddr        = clr_cnt_r;
    d_wdata        = '0;
    mac_ctl        = '0;

    case (state_r)
      ST_CLEAR: begin
        c_we        = clr_coeff_r;
        dl_we       = 1'b1;
        dr_we       = 1'b1;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(MAX_TAPS - 1)) begin
          clr_coeff_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          sl_nxt   = in_tdata[0 +: SAMPLE_W];
          sr_nxt   = in_tdata[SAMPLE_W +: SAMPLE_W];
          yl_nxt   = '0;
          yr_nxt   = '0;
          chan_nxt = (cmd == CMD_RIGHT);
          both_nxt = (cmd == CMD_BOTH);
          case (cmd)
            CMD_LEFT: begin
              mask_nxt  = MASK_LEFT;
              state_nxt = ST_LOAD;
            end
            CMD_RIGHT: begin
              mask_nxt  = MASK_RIGHT;
              state_nxt = ST_LOAD;
            end
            CMD_BOTH: begin
              mask_nxt  = MASK_BOTH;
              state_nxt = ST_LOAD;
            end
            CMD_COEFF: begin
              c_we    = (32'(cidx) < MAX_TAPS);
              c_waddr = ADDR_W'(cidx);
              c_wdata = in_tdata[2*SAMPLE_W+CIDX_W +: SAMPLE_W];
            end
            CMD_FLUSH: begin
              wp_left_nxt  = '0;
              wp_right_nxt = '0;
              clr_cnt_nxt  = '0;
              state_nxt    = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        dl_we        = ~chan_r;
        dr_we        = chan_r;
        d_waddr      = pos;
        d_wdata      = chan_r ? sr_r : sl_r;
        mac_ctl.clear = 1'b1;
        tap_nxt      = '0;
        idx_nxt      = pos;
        if (pos_inc >= n_taps) begin
          if (chan_r) wp_right_nxt = '0;
          else        wp_left_nxt  = '0;
        end else begin
          if (chan_r) wp_right_nxt = ADDR_W'(pos_inc);
          else        wp_left_nxt  = ADDR_W'(pos_inc);
        end
        state_nxt    = ST_MAC;
      end
      ST_MAC: begin
        mac_ctl.issue = 1'b1;
        tap_nxt       = tap_r + ADDR_W'(1);
        idx_nxt       = (idx_r == '0) ? last_tap : idx_r - ADDR_W'(1);
        if (tap_r == last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_sts.busy) begin
          if (chan_r) yr_nxt = mac_sts.y;
          else        yl_nxt = mac_sts.y;
          if (!chan_r && both_r) begin
            chan_nxt  = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {yr_r, yl_r};
          out_tuser_nxt  = mask_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  sfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_coeff_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (tap_r),
    .rdata (c_rdata)
  );

  sfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_dly_left_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (idx_r),
    .rdata (dl_rdata)
  );

  sfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_dly_right_ram (
    .clk   (clk),
    .we    (dr_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (idx_r),
    .rdata (dr_rdata)
  );

  sfir_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .coeff  (c_rdata),
    .sample (chan_r ? dr_rdata : dl_rdata),
    .sts    (mac_sts)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== hw/rtl/sfir_checker.sv =====
// Port-level checks for the stereo FIR filter core, bound to the top level.
module sfir_checker
  import sfir_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [CMD_W-1:0]      in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [MASK_W-1:0]     out_tuser,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata,
  input logic                  cfg_pready
);

  // reset leads into the clearing pass with no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("core not clearing after reset");

  // filter and flush requests leave the core not ready in the cycle after they are taken
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_LEFT || in_tuser == CMD_RIGHT ||
      in_tuser == CMD_BOTH || in_tuser == CMD_FLUSH) |=> !in_tready)
    else $error("core ready right after a filter or flush request");

  a_mask_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != '0 &&
      (out_tuser != MASK_LEFT || out_tdata[SAMPLE_W +: SAMPLE_W] == '0) &&
      (out_tuser != MASK_RIGHT || out_tdata[0 +: SAMPLE_W] == '0))
    else $error("result fields disagree with channel mask");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind stereo_fir_filter_core sfir_checker u_sfir_checker (.*);

// ===== verif/stereo_fir_filter_core_tb.sv =====
// Self-checking testbench for stereo_fir_filter_core: stream requests, APB tap count, FIR predictor.
`timescale 1ns / 1ps

module stereo_fir_filter_core_tb;
  import sfir_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t             left;
    sample_t             right;
    logic [MASK_W-1:0]   mask;
  } fir_result_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(CMD_FLUSH + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;
  // longest busy stretch: both channels at full length, or a flush pass
  localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 16;
  localparam int MAX_REPORTS   = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // sample_left, sample_right, coeff_index, coeff_value
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // command
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_left, out_right
  logic [OUT_DATA_W-1:0] out_tdata;
  // channel_mask
  logic [MASK_W-1:0]     out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  stereo_fir_filter_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("stereo_fir_filter_core verification failed");
    $finish;
  end

  // filter state mirror
  sample_t            coeff_mem [MAX_TAPS];
  sample_t            line_left [MAX_TAPS];
  sample_t            line_right[MAX_TAPS];
  int unsigned        wpos_left;
  int unsigned        wpos_right;
  logic [NTAPS_W-1:0] taps_reg;

  fir_result_t filtered_q[$];

  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned tap_settings;
  bit          no_idle;

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  function automatic int unsigned taps_in_effect();
    if (taps_reg < MIN_TAPS) return MIN_TAPS;
    if (taps_reg > MAX_TAPS) return MAX_TAPS;
    return taps_reg;
  endfunction

  function automatic void clear_lines();
    for (int k = 0; k < MAX_TAPS; k++) begin
      line_left[k]  = '0;
      line_right[k] = '0;
    end
    wpos_left  = 0;
    wpos_right = 0;
  endfunction

  function automatic sample_t fir_channel(input bit right, input sample_t x);
    int unsigned n;
    int unsigned p;
    int unsigned idx;
    sample_t     d;
    longint      acc;
    longint      rounded;
    n = taps_in_effect();
    p = right ? wpos_right : wpos_left;
    if (p >= n) p = 0;
    if (right) line_right[p] = x;
    else line_left[p] = x;
    idx = p;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      d = right ? line_right[idx] : line_left[idx];
      acc += longint'(coeff_mem[i]) * longint'(d);
      idx = (idx == 0) ? n - 1 : idx - 1;
    end
    p = (p + 1 >= n) ? 0 : p + 1;
    if (right) wpos_right = p;
    else wpos_left = p;
    rounded = (acc + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
    if (rounded > longint'(SAMPLE_MAX)) rounded = longint'(SAMPLE_MAX);
    if (rounded < longint'(SAMPLE_MIN)) rounded = longint'(SAMPLE_MIN);
    return sample_t'(rounded);
  endfunction

  function automatic void apply_request(input logic [CMD_W-1:0] cmd, input sample_t sl,
                                        input sample_t sr, input logic [CIDX_W-1:0] ci,
                                        input sample_t cv);
    fir_result_t r;
    r = '0;
    case (cmd)
      CMD_LEFT: begin
        r.left = fir_channel(1'b0, sl);
        r.mask = MASK_LEFT;
        filtered_q.push_back(r);
      end
      CMD_RIGHT: begin
        r.right = fir_channel(1'b1, sr);
        r.mask  = MASK_RIGHT;
        filtered_q.push_back(r);
      end
      CMD_BOTH: begin
        r.left  = fir_channel(1'b0, sl);
        r.right = fir_channel(1'b1, sr);
        r.mask  = MASK_BOTH;
        filtered_q.push_back(r);
      end
      CMD_COEFF: begin
        if (ci < MAX_TAPS) coeff_mem[ci] = cv;
      end
      CMD_FLUSH: clear_lines();
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input sample_t sl, input sample_t sr,
                              input logic [CIDX_W-1:0] ci, input sample_t cv);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {cv, ci, sr, sl};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_request(cmd, sl, sr, ci, cv);
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result-side backpressure
  int unsigned ready_hold;
  int unsigned ready_roll;
  always @(posedge clk) begin
    if (no_idle) begin
      ready_hold = 0;
      out_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 88) begin
        out_tready <= 1'b1;
      end else if (ready_roll < 97) begin
        ready_hold = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        ready_hold = $urandom_range(19, 79);
        out_tready <= 1'b0;
      end
    end
  end

  fir_result_t head;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_q.size() == 0) begin
        note_error($sformatf("unexpected result L=%0d R=%0d mask=%b",
                             $signed(out_tdata[SAMPLE_W-1:0]),
                             $signed(out_tdata[2*SAMPLE_W-1:SAMPLE_W]), out_tuser));
      end else begin
        head = filtered_q.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== head.left ||
            out_tdata[2*SAMPLE_W-1:SAMPLE_W] !== head.right ||
            out_tuser !== head.mask) begin
          note_error($sformatf("result %0d: expected L=%0d R=%0d mask=%b, got L=%0d R=%0d mask=%b",
                               results_checked, head.left, head.right, head.mask,
                               $signed(out_tdata[SAMPLE_W-1:0]),
                               $signed(out_tdata[2*SAMPLE_W-1:SAMPLE_W]), out_tuser));
        end
      end
      results_checked++;
    end
  end

  task automatic apb_access(input bit wr, input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= REG_NUM_TAPS;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_taps_readback();
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[NTAPS_W-1:0] !== taps_reg)
      note_error($sformatf("num_taps readback: expected %0d, got %0d", taps_reg,
                           rd[NTAPS_W-1:0]));
  endtask

  task automatic set_num_taps(input logic [NTAPS_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    wait_idle();
    // upper write bits are don't-care; toggle them anyway
    apb_access(1'b1, {(CFG_DATA_W-NTAPS_W)'($urandom()), value}, rd);
    taps_reg = value;
    tap_settings++;
    check_taps_readback();
  endtask

  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return SAMPLE_MAX;
    if (pick == 1) return SAMPLE_MIN;
    return sample_t'($urandom());
  endfunction

  function automatic sample_t rand_coeff();
    sample_t v;
    v = sample_t'($urandom());
    return v >>> $urandom_range(0, 16);
  endfunction

  task automatic random_request();
    int unsigned         roll;
    logic [CMD_W-1:0]    cmd;
    logic [CIDX_W-1:0]   ci;
    roll = $urandom_range(0, 99);
    if (roll < 25) cmd = CMD_LEFT;
    else if (roll < 50) cmd = CMD_RIGHT;
    else if (roll < 75) cmd = CMD_BOTH;
    else if (roll < 92) cmd = CMD_COEFF;
    else if (roll < 96) cmd = CMD_FLUSH;
    else cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    if ($urandom_range(0, 9) < 7) ci = CIDX_W'($urandom_range(0, taps_in_effect() - 1));
    else ci = CIDX_W'($urandom_range(0, MAX_TAPS - 1));
    send_request(cmd, rand_sample(), rand_sample(), ci, rand_coeff());
  endtask

  task automatic run_random_phase(input logic [NTAPS_W-1:0] taps, input int unsigned count);
    set_num_taps(taps);
    no_idle = ($urandom_range(0, 3) == 0);
    repeat (count) random_request();
    no_idle = 1'b0;
  endtask

  task automatic test_reset_value();
    wait_idle();
    check_taps_readback();
  endtask

  // saturation both ways, rounding of tiny sums, unused field zero, ignored codes, flush
  task automatic test_directed();
    send_request(CMD_COEFF, '0, '0, 8'd0, SAMPLE_MAX);
    send_request(CMD_COEFF, '0, '0, 8'd1, SAMPLE_MIN);
    send_request(CMD_COEFF, '0, '0, 8'd2, sample_t'(1));
    send_request(CMD_COEFF, '0, '0, 8'd255, sample_t'(24'h400000));
    send_request(CMD_LEFT, SAMPLE_MAX, SAMPLE_MIN, 8'd0, '0);
    send_request(CMD_RIGHT, SAMPLE_MAX, SAMPLE_MIN, 8'd0, '0);
    send_request(CMD_BOTH, SAMPLE_MIN, SAMPLE_MAX, 8'd0, '0);
    send_request(CMD_LEFT, '0, SAMPLE_MAX, 8'd0, '0);
    send_request(CMD_RIGHT, SAMPLE_MIN, sample_t'(1), 8'd0, '0);
    send_request(CMD_UNUSED_LO, SAMPLE_MAX, SAMPLE_MAX, 8'd0, SAMPLE_MAX);
    send_request(CMD_UNUSED_HI, SAMPLE_MIN, SAMPLE_MIN, 8'd255, SAMPLE_MIN);
    send_request(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), rand_sample(),
                 rand_sample(), 8'd3, rand_coeff());
    send_request(CMD_FLUSH, SAMPLE_MAX, SAMPLE_MAX, 8'd255, SAMPLE_MAX);
    send_request(CMD_LEFT, sample_t'(24'h400000), '0, 8'd0, '0);
    send_request(CMD_BOTH, sample_t'(1), sample_t'(-1), 8'd0, '0);
    send_request(CMD_COEFF, '0, '0, 8'd0, sample_t'(1));
    send_request(CMD_COEFF, '0, '0, 8'd1, sample_t'(-1));
    send_request(CMD_BOTH, SAMPLE_MAX, SAMPLE_MIN, 8'd0, '0);
    send_request(CMD_BOTH, SAMPLE_MIN, SAMPLE_MAX, 8'd0, '0);
    send_request(CMD_RIGHT, '0, '0, 8'd0, '0);
  endtask

  // below-minimum tap counts; the shrink also forces write positions back to zero
  task automatic test_tap_clamp_low();
    run_random_phase(9'd0, 60);
    run_random_phase(9'd1, 60);
    run_random_phase(9'd2, 60);
    run_random_phase(9'(MIN_TAPS), 60);
  endtask

  task automatic test_random_settings();
    repeat (6) run_random_phase(NTAPS_W'($urandom_range(4, 40)), 115);
    run_random_phase(NTAPS_W'($urandom_range(41, MAX_TAPS - 1)), 70);
  endtask

  task automatic test_full_length();
    run_random_phase(9'(MAX_TAPS), 40);
    run_random_phase('1, 40);
    run_random_phase(NTAPS_W'($urandom_range(MAX_TAPS + 1, (1 << NTAPS_W) - 2)), 40);
    run_random_phase(9'd5, 20);
  endtask

  initial begin
    taps_reg = NUM_TAPS_RST;
    for (int k = 0; k < MAX_TAPS; k++) coeff_mem[k] = '0;
    clear_lines();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_value();
    test_directed();
    test_tap_clamp_low();
    test_random_settings();
    test_full_length();
    wait_idle();
    $display("Summary: %0d requests sent, %0d results checked over %0d tap settings",
             requests_sent, results_checked, tap_settings + 1);
    $display("Summary: tap count clamps, saturation, flush and ignored codes exercised, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("stereo_fir_filter_core verification clean");
    end else begin
      $display("stereo_fir_filter_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sfir_pkg.sv
hw/rtl/sfir_ram.sv
hw/rtl/sfir_mac.sv
hw/rtl/stereo_fir_filter_core.sv
hw/rtl/sfir_checker.sv
verif/stereo_fir_filter_core_tb.sv
